@@ rtl/core/irfq_pkg.sv @@
// Shared types and codes for the infrared frame transmit and receive queues.
package irfq_pkg;

  // One frame: protocol code and three data bytes.
  typedef struct packed {
    logic [2:0] protocol;
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
  } frame_t;

  // Ring status seen by the control logic.
  typedef struct packed {
    logic empty;
    logic full;
    logic empty_nxt;
  } ring_stat_t;

  // Request codes.
  localparam logic [1:0] OP_SEND    = 2'd0;
  localparam logic [1:0] OP_TX_DONE = 2'd1;
  localparam logic [1:0] OP_RX      = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  // Protocol codes that need masking.
  localparam logic [2:0] PROTO_SIRC15 = 3'd4;
  localparam logic [2:0] PROTO_SIRC20 = 3'd5;
  localparam logic [7:0] SIRC20_MASK  = 8'h1F;

  // Result kinds.
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TX   = 2'd1;
  localparam logic [1:0] KIND_RX   = 2'd2;

  // Status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_DROP  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

endpackage

@@ rtl/core/irfq_ring.sv @@
// Circular frame queue with one slot kept empty and a prefetched head entry.
module irfq_ring #(
  parameter int DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  irfq_pkg::frame_t   push_data,
  input  logic               pop,
  output irfq_pkg::frame_t   head_data,
  output irfq_pkg::ring_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  irfq_pkg::frame_t store_r [DEPTH];
  irfq_pkg::frame_t rd_data_r;
  logic [AW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    tail_r, tail_nxt;
  logic [AW-1:0]    head_inc, tail_inc;

  // Pointer increments wrap at the depth, which need not be a power of two.
  assign head_inc = (head_r == LAST) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == LAST) ? '0 : tail_r + 1'b1;

  assign head_nxt = pop  ? head_inc : head_r;
  assign tail_nxt = push ? tail_inc : tail_r;

  assign stat.empty     = (head_r == tail_r);
  assign stat.full      = (tail_inc == head_r);
  assign stat.empty_nxt = (head_nxt == tail_nxt);
  assign head_data      = rd_data_r;

  // Pointer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  // Frame storage, written at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[tail_r] <= push_data;
    end
  end

  // Registered read of the next head entry. A frame written into the slot
  // that becomes the head is forwarded, since the array still holds old data.
  always_ff @(posedge clk) begin
    if (push && (tail_r == head_nxt)) begin
      rd_data_r <= push_data;
    end else begin
      rd_data_r <= store_r[head_nxt];
    end
  end

endmodule

@@ rtl/core/ir_frame_tx_rx_queue.sv @@
// Infrared frame queues: send masking, transmit queue, receive ring and result register.
// Latency: a result is valid in the cycle after its request beat is accepted.
// Throughput: one request per cycle while the result register is free; it is set by one
// combinational pass over the request, the ring pointers and the prefetched ring heads.
// Reset: both rings empty, transmitter idle, no result pending. Frame storage is
// not cleared; only written entries are ever read.
module ir_frame_tx_rx_queue #(
  parameter int TX_DEPTH = 8,
  parameter int RX_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_opcode,
  input  logic [2:0] in_protocol,
  input  logic [7:0] in_byte_zero,
  input  logic [7:0] in_byte_one,
  input  logic [7:0] in_byte_two,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [2:0] out_protocol,
  output logic [7:0] out_byte_zero,
  output logic [7:0] out_byte_one,
  output logic [7:0] out_byte_two,
  output logic [1:0] out_status,
  output logic       out_transmitter_idle,
  output logic       out_tx_queue_empty,
  output logic       out_rx_queue_empty
);

  logic                 in_fire;
  irfq_pkg::frame_t     raw_frame, send_frame;
  irfq_pkg::frame_t     tx_head, rx_head;
  irfq_pkg::ring_stat_t tx_stat, rx_stat;
  logic                 tx_push, tx_pop, rx_push, rx_pop;

  logic                 idle_r, idle_nxt;
  logic                 out_valid_r;
  logic [1:0]           kind_nxt, kind_r;
  logic [1:0]           status_nxt, status_r;
  irfq_pkg::frame_t     frame_nxt, frame_r;
  logic                 tx_empty_r, rx_empty_r;

  // The result register frees up when it is empty or being drained.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign raw_frame = '{protocol: in_protocol, byte_zero: in_byte_zero,
                       byte_one: in_byte_one, byte_two: in_byte_two};

  // Send masking for the SIRC variants.
  always_comb begin
    send_frame = raw_frame;
    if (in_protocol == irfq_pkg::PROTO_SIRC15) begin
      send_frame.byte_zero = '0;
    end else if (in_protocol == irfq_pkg::PROTO_SIRC20) begin
      send_frame.byte_one = in_byte_one & irfq_pkg::SIRC20_MASK;
    end
  end

  // Request decode: queue operations and the result fields.
  always_comb begin
    tx_push    = 1'b0;
    tx_pop     = 1'b0;
    rx_push    = 1'b0;
    rx_pop     = 1'b0;
    idle_nxt   = idle_r;
    kind_nxt   = irfq_pkg::KIND_NONE;
    status_nxt = irfq_pkg::STAT_OK;
    frame_nxt  = '0;
    if (in_fire) begin
      unique case (in_opcode)
        irfq_pkg::OP_SEND: begin
          if (idle_r && tx_stat.empty) begin
            idle_nxt  = 1'b0;
            kind_nxt  = irfq_pkg::KIND_TX;
            frame_nxt = send_frame;
          end else if (!tx_stat.full) begin
            tx_push = 1'b1;
          end else begin
            status_nxt = irfq_pkg::STAT_DROP;
          end
        end
        irfq_pkg::OP_TX_DONE: begin
          if (!tx_stat.empty) begin
            tx_pop    = 1'b1;
            idle_nxt  = 1'b0;
            kind_nxt  = irfq_pkg::KIND_TX;
            frame_nxt = tx_head;
          end else begin
            idle_nxt = 1'b1;
          end
        end
        irfq_pkg::OP_RX: begin
          if (!rx_stat.full) begin
            rx_push = 1'b1;
          end else begin
            status_nxt = irfq_pkg::STAT_DROP;
          end
        end
        irfq_pkg::OP_READ: begin
          if (!rx_stat.empty) begin
            rx_pop    = 1'b1;
            kind_nxt  = irfq_pkg::KIND_RX;
            frame_nxt = rx_head;
          end else begin
            status_nxt = irfq_pkg::STAT_EMPTY;
          end
        end
      endcase
    end
  end

  // Transmit queue.
  irfq_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tx_push),
    .push_data (send_frame),
    .pop       (tx_pop),
    .head_data (tx_head),
    .stat      (tx_stat)
  );

  // Receive queue, stored without masking.
  irfq_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rx_push),
    .push_data (raw_frame),
    .pop       (rx_pop),
    .head_data (rx_head),
    .stat      (rx_stat)
  );

  // Control state: transmitter idle flag and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      idle_r <= idle_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, loaded on each accepted beat.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r     <= kind_nxt;
      status_r   <= status_nxt;
      frame_r    <= frame_nxt;
      tx_empty_r <= tx_stat.empty_nxt;
      rx_empty_r <= rx_stat.empty_nxt;
    end
  end

  // The idle flag register already holds the post-step value.
  assign out_valid            = out_valid_r;
  assign out_kind             = kind_r;
  assign out_protocol         = frame_r.protocol;
  assign out_byte_zero        = frame_r.byte_zero;
  assign out_byte_one         = frame_r.byte_one;
  assign out_byte_two         = frame_r.byte_two;
  assign out_status           = status_r;
  assign out_transmitter_idle = idle_r;
  assign out_tx_queue_empty   = tx_empty_r;
  assign out_rx_queue_empty   = rx_empty_r;

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the infrared frame transmit and receive queues.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TXD = 8;
  localparam int RXD = 8;
  localparam int TXA = $clog2(TXD);
  localparam int RXA = $clog2(RXD);

  // Expected contents of one result beat.
  typedef struct {
    logic [1:0]       kind;
    irfq_pkg::frame_t fr;
    logic [1:0]       status;
    logic             tx_idle;
    logic             tx_empty;
    logic             rx_empty;
  } queue_response_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_opcode = irfq_pkg::OP_SEND;
  logic [2:0] in_protocol = 3'd0;
  logic [7:0] in_byte_zero = 8'h00;
  logic [7:0] in_byte_one = 8'h00;
  logic [7:0] in_byte_two = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [2:0] out_protocol;
  logic [7:0] out_byte_zero;
  logic [7:0] out_byte_one;
  logic [7:0] out_byte_two;
  logic [1:0] out_status;
  logic       out_transmitter_idle;
  logic       out_tx_queue_empty;
  logic       out_rx_queue_empty;

  ir_frame_tx_rx_queue #(
    .TX_DEPTH(TXD),
    .RX_DEPTH(RXD)
  ) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_protocol         (in_protocol),
    .in_byte_zero        (in_byte_zero),
    .in_byte_one         (in_byte_one),
    .in_byte_two         (in_byte_two),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_protocol        (out_protocol),
    .out_byte_zero       (out_byte_zero),
    .out_byte_one        (out_byte_one),
    .out_byte_two        (out_byte_two),
    .out_status          (out_status),
    .out_transmitter_idle(out_transmitter_idle),
    .out_tx_queue_empty  (out_tx_queue_empty),
    .out_rx_queue_empty  (out_rx_queue_empty)
  );

  always #1 clk = ~clk;

  // Shadow copy of both rings and the transmitter state.
  irfq_pkg::frame_t tx_slots [TXD];
  irfq_pkg::frame_t rx_slots [RXD];
  int     tx_rd = 0;
  int     tx_wr = 0;
  int     rx_rd = 0;
  int     rx_wr = 0;
  logic   tx_idle_m = 1'b1;

  queue_response_t pending_responses[$];
  int errors = 0;

  // Sender burst shaping and receiver hold-off request.
  int   burst_left = 4;
  logic gaps_on = 1'b1;
  logic hold_req = 1'b0;

  // Apply one request to the shadow state and return the response it causes.
  function automatic queue_response_t next_queue_response(input logic [1:0] op,
                                                           input irfq_pkg::frame_t req);
    queue_response_t r;
    irfq_pkg::frame_t f;
    f = req;
    r.kind = irfq_pkg::KIND_NONE;
    r.fr = '0;
    r.status = irfq_pkg::STAT_OK;
    case (op)
      irfq_pkg::OP_SEND: begin
        if (f.protocol == irfq_pkg::PROTO_SIRC15) f.byte_zero = 8'h00;
        else if (f.protocol == irfq_pkg::PROTO_SIRC20)
          f.byte_one = f.byte_one & irfq_pkg::SIRC20_MASK;
        if (tx_idle_m && tx_rd == tx_wr) begin
          tx_idle_m = 1'b0;
          r.kind = irfq_pkg::KIND_TX;
          r.fr = f;
        end else if ((tx_wr + 1) % TXD != tx_rd) begin
          tx_slots[TXA'(tx_wr)] = f;
          tx_wr = (tx_wr + 1) % TXD;
        end else begin
          r.status = irfq_pkg::STAT_DROP;
        end
      end
      irfq_pkg::OP_TX_DONE: begin
        tx_idle_m = 1'b1;
        if (tx_rd != tx_wr) begin
          tx_idle_m = 1'b0;
          r.kind = irfq_pkg::KIND_TX;
          r.fr = tx_slots[TXA'(tx_rd)];
          tx_rd = (tx_rd + 1) % TXD;
        end
      end
      irfq_pkg::OP_RX: begin
        // Received frames are stored exactly as they arrive.
        if ((rx_wr + 1) % RXD != rx_rd) begin
          rx_slots[RXA'(rx_wr)] = f;
          rx_wr = (rx_wr + 1) % RXD;
        end else begin
          r.status = irfq_pkg::STAT_DROP;
        end
      end
      default: begin
        if (rx_rd != rx_wr) begin
          r.kind = irfq_pkg::KIND_RX;
          r.fr = rx_slots[RXA'(rx_rd)];
          rx_rd = (rx_rd + 1) % RXD;
        end else begin
          r.status = irfq_pkg::STAT_EMPTY;
        end
      end
    endcase
    r.tx_idle = tx_idle_m;
    r.tx_empty = (tx_rd == tx_wr);
    r.rx_empty = (rx_rd == rx_wr);
    return r;
  endfunction

  function automatic irfq_pkg::frame_t make_frame(input logic [2:0] proto,
                                                  input logic [7:0] b0,
                                                  input logic [7:0] b1,
                                                  input logic [7:0] b2);
    irfq_pkg::frame_t f;
    f.protocol = proto;
    f.byte_zero = b0;
    f.byte_one = b1;
    f.byte_two = b2;
    return f;
  endfunction

  // Bytes lean toward the all-zero and all-one corners.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one request beat, wait for acceptance, then maybe open a gap.
  task automatic offer_frame(input logic [1:0] op, input irfq_pkg::frame_t fr);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_protocol <= fr.protocol;
    in_byte_zero <= fr.byte_zero;
    in_byte_one <= fr.byte_one;
    in_byte_two <= fr.byte_two;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_responses.push_back(next_queue_response(op, fr));
    if (gaps_on) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  // Stop offering and wait for every outstanding response.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Compare every accepted result beat with the oldest expected response.
  always @(posedge clk) begin : check_results
    queue_response_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_responses.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected, expected nothing, got kind %0h",
                 $time, out_kind);
      end else begin
        want = pending_responses.pop_front();
        check_field("kind", 8'(want.kind), 8'(out_kind));
        check_field("protocol", 8'(want.fr.protocol), 8'(out_protocol));
        check_field("byte_zero", want.fr.byte_zero, out_byte_zero);
        check_field("byte_one", want.fr.byte_one, out_byte_one);
        check_field("byte_two", want.fr.byte_two, out_byte_two);
        check_field("status", 8'(want.status), 8'(out_status));
        check_field("transmitter_idle", 8'(want.tx_idle), 8'(out_transmitter_idle));
        check_field("tx_queue_empty", 8'(want.tx_empty), 8'(out_tx_queue_empty));
        check_field("rx_queue_empty", 8'(want.rx_empty), 8'(out_rx_queue_empty));
      end
    end
  end

  // Receiver: stall modes of random length, plus a long hold-off on request.
  int unsigned ready_mode = 0;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 7) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Masking, unused protocol codes, a full transmit queue and draining it.
  task automatic test_transmit_path();
    offer_frame(irfq_pkg::OP_SEND, make_frame(3'd0, 8'h00, 8'h00, 8'h00));
    offer_frame(irfq_pkg::OP_SEND, make_frame(irfq_pkg::PROTO_SIRC15, 8'hFF, 8'hFF, 8'hFF));
    offer_frame(irfq_pkg::OP_SEND, make_frame(irfq_pkg::PROTO_SIRC20, 8'hFF, 8'hFF, 8'hFF));
    offer_frame(irfq_pkg::OP_SEND, make_frame(3'd7, 8'hFF, 8'hFF, 8'hFF));
    offer_frame(irfq_pkg::OP_SEND, make_frame(3'd6, 8'hA5, 8'h5A, 8'hC3));
    offer_frame(irfq_pkg::OP_SEND, make_frame(3'd3, 8'hFF, 8'h00, 8'hFF));
    offer_frame(irfq_pkg::OP_SEND, make_frame(3'd1, 8'h12, 8'h34, 8'h56));
    offer_frame(irfq_pkg::OP_SEND, make_frame(3'd2, 8'h00, 8'hFF, 8'h00));
    // The queue is full now, so this frame is dropped.
    offer_frame(irfq_pkg::OP_SEND, make_frame(3'd0, 8'hFF, 8'hFF, 8'hFF));
    // Seven dones start the queued frames, the eighth finds the queue empty.
    repeat (8) offer_frame(irfq_pkg::OP_TX_DONE, make_frame(3'd0, 8'h00, 8'h00, 8'h00));
    // Done while already idle.
    offer_frame(irfq_pkg::OP_TX_DONE, make_frame(3'd7, 8'hFF, 8'hFF, 8'hFF));
    drain_results();
  endtask

  // Received frames are kept unmasked; reading past the end reports empty.
  task automatic test_receive_path();
    offer_frame(irfq_pkg::OP_RX, make_frame(irfq_pkg::PROTO_SIRC20, 8'hFF, 8'hFF, 8'hFF));
    offer_frame(irfq_pkg::OP_RX, make_frame(3'd7, 8'h00, 8'h00, 8'h00));
    offer_frame(irfq_pkg::OP_READ, make_frame(3'd0, 8'h00, 8'h00, 8'h00));
    offer_frame(irfq_pkg::OP_READ, make_frame(3'd0, 8'h00, 8'h00, 8'h00));
    offer_frame(irfq_pkg::OP_READ, make_frame(3'd0, 8'h00, 8'h00, 8'h00));
    drain_results();
  endtask

  // Random requests with the given weights in percent; reads take the rest.
  task automatic run_random(input int count, input int w_send, input int w_done,
                            input int w_rx);
    int v;
    logic [1:0] op;
    for (int i = 0; i < count; i++) begin
      v = $urandom_range(0, 99);
      if (v < w_send) op = irfq_pkg::OP_SEND;
      else if (v < w_send + w_done) op = irfq_pkg::OP_TX_DONE;
      else if (v < w_send + w_done + w_rx) op = irfq_pkg::OP_RX;
      else op = irfq_pkg::OP_READ;
      offer_frame(op, make_frame(3'($urandom_range(0, 7)), pick_byte(), pick_byte(),
                                 pick_byte()));
    end
  endtask

  // Phases that push each ring toward full and toward empty.
  task automatic test_random_mix();
    run_random(150, 25, 25, 25);
    drain_results();
    run_random(100, 60, 20, 10);
    drain_results();
    run_random(100, 20, 60, 10);
    drain_results();
    run_random(100, 10, 10, 60);
    drain_results();
    run_random(100, 10, 10, 20);
    drain_results();
    // A stretch with no sender gaps at all.
    gaps_on = 1'b0;
    run_random(150, 25, 25, 25);
    drain_results();
    gaps_on = 1'b1;
  endtask

  // The receiver holds off for a long time while requests keep coming.
  task automatic test_backpressure();
    hold_req = 1'b1;
    gaps_on = 1'b0;
    run_random(50, 25, 25, 25);
    drain_results();
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_transmit_path();
    test_receive_path();
    test_random_mix();
    test_backpressure();
    if (errors == 0) begin
      $display("ir_frame_tx_rx_queue: match");
    end else begin
      $display("ir_frame_tx_rx_queue: mismatch");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #1000000;
    $display("ir_frame_tx_rx_queue: mismatch");
    $finish;
  end

endmodule
